// ----- sv/button_click_classifier_top_assert.svh -----
// assertion macros shared by the button click classifier modules
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/bcc_pkg.sv -----
// shared types and constants of the button click classifier
// no dependencies
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int NUM_KEYS   = 3;
    localparam int KEY_IDX_W  = 2;
    localparam int KEY_SEL_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [TICK_W-1:0] t_ticks;

    localparam t_ticks TICK_MAX          = '1;
    localparam t_ticks RST_DEBOUNCE      = 16'd20;
    localparam t_ticks RST_LONG_PRESS    = 16'd1000;
    localparam t_ticks RST_DOUBLE_WINDOW = 16'd300;
    localparam t_ticks RST_RELEASE_POLL  = 16'd50;

    typedef enum logic [1:0] {
        EV_SINGLE = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_LONG   = 2'd2
    } t_ev_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE      = 2'd0,
        REG_LONG_PRESS    = 2'd1,
        REG_DOUBLE_WINDOW = 2'd2,
        REG_RELEASE_POLL  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_ticks debounce;
        t_ticks long_press;
        t_ticks double_window;
        t_ticks release_poll;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        t_ev_code code;
    } t_event;

endpackage

// ----- sv/bcc_lane.sv -----
// one button lane: debounce countdown, elapsed counter and click classifier
// depends on bcc_pkg and button_click_classifier_top_assert.svh
`timescale 1ns / 1ps
`include "button_click_classifier_top_assert.svh"

module bcc_lane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_level,
    input  bcc_pkg::t_cfg   i_cfg,
    output bcc_pkg::t_event o_event
);
    import bcc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_DEB  = 3'd1,
        PH_WREL = 3'd2,
        PH_WSEC = 3'd3,
        PH_DEB2 = 3'd4,
        PH_RELW = 3'd5
    } t_phase;

    t_phase r_phase, n_phase;
    t_ticks r_cnt, n_cnt;
    t_ticks r_elapsed, n_elapsed;
    logic   r_run, n_run;
    logic   r_prev, n_prev;
    logic   expire;
    t_event ev;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_run     = r_run;
        n_prev    = r_prev;
        n_elapsed = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + t_ticks'(1);
        expire    = 1'b0;
        ev        = '0;

        // a level change reloads the countdown and wins over expiry
        if (i_level != r_prev) begin
            n_prev = i_level;
            n_cnt  = i_cfg.debounce;
            n_run  = 1'b1;
        end else if (r_run) begin
            if (r_cnt <= t_ticks'(1)) begin
                n_cnt  = '0;
                n_run  = 1'b0;
                expire = 1'b1;
            end else begin
                n_cnt = r_cnt - t_ticks'(1);
            end
        end

        if (expire) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!i_level) begin
                        n_phase   = PH_DEB;
                        n_elapsed = '0;
                        n_cnt     = i_cfg.debounce;
                        n_run     = 1'b1;
                    end
                end
                PH_DEB: begin
                    if (!i_level) begin
                        n_phase = PH_WREL;
                        n_cnt   = i_cfg.long_press;
                        n_run   = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_WREL: begin
                    if (!i_level) begin
                        // still held: long press once enough ticks have gone by
                        if (n_elapsed >= i_cfg.long_press) begin
                            ev.valid = 1'b1;
                            ev.code  = EV_LONG;
                            n_phase  = PH_RELW;
                            n_cnt    = i_cfg.release_poll;
                            n_run    = 1'b1;
                        end
                    end else begin
                        n_phase = PH_WSEC;
                        n_cnt   = i_cfg.double_window;
                        n_run   = 1'b1;
                    end
                end
                PH_WSEC: begin
                    if (!i_level) begin
                        n_phase = PH_DEB2;
                        n_cnt   = i_cfg.debounce;
                        n_run   = 1'b1;
                    end else begin
                        ev.valid = 1'b1;
                        ev.code  = EV_SINGLE;
                        n_phase  = PH_IDLE;
                        n_run    = 1'b0;
                    end
                end
                PH_DEB2: begin
                    if (!i_level) begin
                        ev.valid = 1'b1;
                        ev.code  = EV_DOUBLE;
                        n_phase  = PH_RELW;
                        n_cnt    = i_cfg.release_poll;
                        n_run    = 1'b1;
                    end else begin
                        ev.valid = 1'b1;
                        ev.code  = EV_SINGLE;
                        n_phase  = PH_IDLE;
                    end
                end
                PH_RELW: begin
                    if (i_level) begin
                        n_phase = PH_IDLE;
                        n_run   = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_run   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_run     <= 1'b0;
            r_elapsed <= '0;
            r_prev    <= 1'b1;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_run     <= n_run;
            r_elapsed <= n_elapsed;
            r_prev    <= n_prev;
        end
    end

    assign o_event = ev;

    `BCC_ASSERT_IMP(a_event_on_expiry, i_clk, i_rst_n, i_step && o_event.valid, r_run && (r_cnt <= t_ticks'(1)) && (i_level == r_prev), "event without countdown expiry")
    `BCC_ASSERT_IMP(a_wrel_from_deb, i_clk, i_rst_n, (r_phase == PH_WREL) && ($past(r_phase) != PH_WREL), $past(r_phase) == PH_DEB, "wait release entered from wrong phase")

endmodule

// ----- sv/bcc_merge.sv -----
// merging stage: holds the events of one tick and hands them out in button order
// depends on bcc_pkg and button_click_classifier_top_assert.svh
`timescale 1ns / 1ps
`include "button_click_classifier_top_assert.svh"

module bcc_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bcc_pkg::t_event [bcc_pkg::NUM_KEYS-1:0] i_events,
    output logic                             o_load,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bcc_pkg::KEY_IDX_W-1:0]    o_key_index,
    output logic [1:0]                       o_event_code,
    output logic                             o_last_event
);
    import bcc_pkg::*;

    logic     [NUM_KEYS-1:0]  r_pend, n_pend;
    t_ev_code                 r_code [NUM_KEYS];
    logic     [KEY_SEL_W-1:0] sel;
    logic                     found;
    logic     [NUM_KEYS-1:0]  rest;
    logic     [NUM_KEYS-1:0]  cleared;
    logic     [NUM_KEYS-1:0]  new_mask;
    logic                     out_take;
    logic                     load;

    // lowest pending button goes first
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (r_pend[k] && !found) begin
                found = 1'b1;
                sel   = KEY_SEL_W'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            new_mask[k] = i_events[k].valid;
        end
    end

    assign rest       = r_pend & ~(NUM_KEYS'(1) << sel);
    assign out_take   = o_out_valid && i_out_ready;
    assign cleared    = out_take ? rest : r_pend;
    // take the next tick as soon as the last word of this one leaves
    assign o_in_ready = (cleared == '0);
    assign load       = i_in_valid && o_in_ready;
    assign n_pend     = load ? new_mask : cleared;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_code[k] <= i_events[k].code;
            end
        end
    end

    assign o_load       = load;
    assign o_out_valid  = |r_pend;
    assign o_key_index  = KEY_IDX_W'(sel);
    assign o_event_code = r_code[sel];
    assign o_last_event = (rest == '0);

    `BCC_ASSERT_IMP(a_last_matches_count, i_clk, i_rst_n, o_out_valid, o_last_event == ($countones(r_pend) == 1), "last flag disagrees with pending count")
    `BCC_ASSERT_NEXT(a_drain_one, i_clk, i_rst_n, out_take && !load, $countones(r_pend) + 1 == $countones($past(r_pend)), "delivered word not retired")
    `BCC_ASSERT_IMP(a_load_after_last, i_clk, i_rst_n, load && (r_pend != '0), out_take && o_last_event, "new tick loaded over pending words")

endmodule

// ----- sv/button_click_classifier_top.sv -----
// Button click classifier: one input word is one time tick with the sampled
// active-low level of every button; each button runs its own debounce
// countdown and classifier lane, and single, double and long press events come
// out one word per cycle while i_out_ready is high, in ascending button order,
// last_event marking the final event of a tick. A tick is taken every cycle
// while it causes no event; a tick with n events holds the merging stage until
// all n are taken, n at most the number of buttons. The next tick is accepted
// in the cycle the last event of the previous one is taken.
// depends on bcc_pkg, bcc_lane and bcc_merge
`timescale 1ns / 1ps

module button_click_classifier_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcc_pkg::TICK_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bcc_pkg::NUM_KEYS-1:0]  i_key_levels,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bcc_pkg::KEY_IDX_W-1:0] o_key_index,
    output logic [1:0]                    o_event_code,
    output logic                          o_last_event
);
    import bcc_pkg::*;

    t_cfg                  r_cfg;
    t_event [NUM_KEYS-1:0] events;
    logic                  load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce      <= RST_DEBOUNCE;
            r_cfg.long_press    <= RST_LONG_PRESS;
            r_cfg.double_window <= RST_DOUBLE_WINDOW;
            r_cfg.release_poll  <= RST_RELEASE_POLL;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DEBOUNCE:      r_cfg.debounce      <= i_cfg_data;
                REG_LONG_PRESS:    r_cfg.long_press    <= i_cfg_data;
                REG_DOUBLE_WINDOW: r_cfg.double_window <= i_cfg_data;
                REG_RELEASE_POLL:  r_cfg.release_poll  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        bcc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (load),
            .i_level (i_key_levels[g]),
            .i_cfg   (r_cfg),
            .o_event (events[g])
        );
    end

    bcc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_events     (events),
        .o_load       (load),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_key_index  (o_key_index),
        .o_event_code (o_event_code),
        .o_last_event (o_last_event)
    );

endmodule
